// File: design/dtt_pkg.sv
`default_nettype none
package dtt_pkg;
  localparam int SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 48;
  localparam int MAX_OUT = 16;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_TICK   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ADD    = 2'd0,
    KIND_CANCEL = 2'd1,
    KIND_FIRED  = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN_ADD,
    ST_WRITE_ADD,
    ST_PICK,
    ST_PICK_DONE,
    ST_REARM,
    ST_REARM_W,
    ST_EARLY,
    ST_EMIT,
    ST_WAIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       scan_clr;
    logic       scan_add;
    logic       scan_pick;
    logic       scan_early;
    logic       write_add;
    logic       do_cancel;
    logic       take_pick;
    logic       rearm_rd;
    logic       rearm_wr;
    logic       emit_load;
    logic       emit_adv;
  } dtt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       scan_done;
    logic       pick_found;
    logic       list_full;
    logic       rearm_done;
    logic       emit_last;
    cmd_t       cmd;
  } dtt_sts_t;
endpackage
`default_nettype wire

// File: design/dtt_ctrl.sv
`default_nettype none
module dtt_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_fire,
  output logic                busy,
  output logic                out_valid,
  input  wire                 out_ready,
  output dtt_pkg::dtt_cmd_t   cmd,
  input  dtt_pkg::dtt_sts_t   sts
);
  import dtt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt = ST_SCAN_ADD;
        end
      end
      ST_SCAN_ADD: begin
        case (sts.cmd)
          CMD_ADD: begin
            cmd.scan_add = 1'b1;
            if (sts.scan_done) state_nxt = ST_WRITE_ADD;
          end
          CMD_CANCEL: begin
            cmd.do_cancel = 1'b1;
            cmd.scan_clr = 1'b1;
            state_nxt = ST_EARLY;
          end
          CMD_TICK: begin
            state_nxt = ST_PICK;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      ST_WRITE_ADD: begin
        cmd.write_add = 1'b1;
        cmd.scan_clr = 1'b1;
        state_nxt = ST_EARLY;
      end
      ST_PICK: begin
        cmd.scan_pick = 1'b1;
        if (sts.scan_done) state_nxt = ST_PICK_DONE;
      end
      ST_PICK_DONE: begin
        cmd.scan_clr = 1'b1;
        if (sts.pick_found) begin
          cmd.take_pick = 1'b1;
          state_nxt = sts.list_full ? ST_REARM : ST_PICK;
        end else begin
          state_nxt = ST_REARM;
        end
      end
      ST_REARM: begin
        cmd.rearm_rd = 1'b1;
        state_nxt = ST_REARM_W;
      end
      ST_REARM_W: begin
        cmd.rearm_wr = 1'b1;
        if (sts.rearm_done) begin
          cmd.scan_clr = 1'b1;
          state_nxt = ST_EARLY;
        end else begin
          state_nxt = ST_REARM;
        end
      end
      ST_EARLY: begin
        cmd.scan_early = 1'b1;
        if (sts.scan_done) state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.emit_load = 1'b1;
        state_nxt = ST_WAIT;
      end
      ST_WAIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.emit_adv = 1'b1;
          if (sts.emit_last) state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: design/dtt_dpath.sv
`default_nettype none
module dtt_dpath #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [1:0]            in_cmd,
  input  wire  [3:0]            in_slot_id,
  input  wire  [47:0]           in_time_us,
  input  wire  [47:0]           in_repeat_us,
  input  dtt_pkg::dtt_cmd_t     cmd,
  output dtt_pkg::dtt_sts_t     sts,
  output logic [1:0]            out_kind,
  output logic [3:0]            out_fired_id,
  output logic                  out_earliest_changed,
  output logic                  out_any_armed,
  output logic [47:0]           out_next_deadline,
  output logic                  out_last
);
  import dtt_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int NW = $clog2(MAX_OUT + 1);
  localparam int LW = $clog2(MAX_OUT);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [SLOTS-1:0]     armed_r;
  logic [TIME_BITS-1:0] dl_mem [SLOTS];
  logic [TIME_BITS-1:0] per_mem [SLOTS];

  cmd_t                 cmd_r;
  logic [3:0]           id_r;
  logic [TIME_BITS-1:0] t_r, rep_r;

  logic [CW-1:0]        scan_r;
  logic [TIME_BITS-1:0] rd_dl_r;
  logic                 rd_ok_r;
  logic [IW-1:0]        rd_idx_r;
  logic                 best_ok_r;
  logic [TIME_BITS-1:0] best_r;
  logic [IW-1:0]        best_idx_r;
  logic [SLOTS-1:0]     taken_r;
  logic                 chg_r;

  logic [IW-1:0]        list_r [MAX_OUT];
  logic [NW-1:0]        n_r;
  logic [NW-1:0]        k_r;
  logic [TIME_BITS-1:0] per_rd_r;
  logic [IW-1:0]        rs_r;
  logic [TIME_BITS:0]   sum;

  logic                 id_ok;
  logic [IW-1:0]        id_ix;
  logic                 cand;
  logic                 better;

  assign id_ok = ({28'd0, id_r} < 32'(SLOTS));
  assign id_ix = IW'(id_r);
  assign sum = {1'b0, t_r} + {1'b0, per_rd_r};

  // candidate filter for the stage-two compare
  always_comb begin
    cand = rd_ok_r;
    if (cmd.scan_add) cand = rd_ok_r && !(id_ok && rd_idx_r == id_ix);
    if (cmd.scan_pick) cand = rd_ok_r && !taken_r[rd_idx_r] && rd_dl_r <= t_r;
    better = cand && (!best_ok_r || rd_dl_r < best_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r <= cmd_t'(in_cmd);
      id_r <= in_slot_id;
      t_r <= TIME_BITS'(in_time_us);
      rep_r <= TIME_BITS'(in_repeat_us);
    end
    rd_dl_r <= dl_mem[IW'(scan_r)];
    rd_idx_r <= IW'(scan_r);
    if (cmd.write_add && id_ok) begin
      dl_mem[id_ix] <= t_r;
      per_mem[id_ix] <= rep_r;
    end
    if (cmd.rearm_rd) begin
      rs_r <= list_r[LW'(k_r)];
      per_rd_r <= per_mem[list_r[LW'(k_r)]];
    end
    if (cmd.rearm_wr && k_r < n_r && per_rd_r != '0) begin
      dl_mem[rs_r] <= (sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0]);
    end
    if (cmd.take_pick) list_r[LW'(n_r)] <= best_idx_r;
    if ((cmd.scan_add || cmd.scan_pick || cmd.scan_early) && better) begin
      best_r <= rd_dl_r;
      best_idx_r <= rd_idx_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r <= '0;
      scan_r <= '0;
      rd_ok_r <= 1'b0;
      best_ok_r <= 1'b0;
      taken_r <= '0;
      n_r <= '0;
      k_r <= '0;
      chg_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        taken_r <= '0;
        n_r <= '0;
        k_r <= '0;
      end
      if (cmd.scan_clr) begin
        scan_r <= '0;
        rd_ok_r <= 1'b0;
        best_ok_r <= 1'b0;
      end else if (cmd.scan_add || cmd.scan_pick || cmd.scan_early) begin
        if (scan_r < CW'(SLOTS)) scan_r <= scan_r + 1'b1;
        rd_ok_r <= (scan_r < CW'(SLOTS)) && armed_r[IW'(scan_r)];
        if (better) best_ok_r <= 1'b1;
      end
      if (cmd.write_add) begin
        chg_r <= id_ok && (!best_ok_r || t_r < best_r);
        if (id_ok) armed_r[id_ix] <= 1'b1;
      end
      if (cmd.do_cancel && id_ok) armed_r[id_ix] <= 1'b0;
      if (cmd.take_pick) begin
        taken_r[best_idx_r] <= 1'b1;
        n_r <= n_r + 1'b1;
      end
      if (cmd.rearm_wr) begin
        if (k_r < n_r && per_rd_r == '0) armed_r[rs_r] <= 1'b0;
        // back to the first fired slot for the result beats
        if (sts.rearm_done) k_r <= '0;
        else k_r <= k_r + 1'b1;
      end
      if (cmd.emit_adv) k_r <= k_r + 1'b1;
    end
  end

  // the scan is done once the read pipeline has drained: all slots read and rd_ok_r clear
  assign sts.scan_done = (scan_r == CW'(SLOTS)) && !rd_ok_r;
  assign sts.pick_found = best_ok_r;
  assign sts.list_full = (n_r + 1'b1 == NW'(MAX_OUT));
  assign sts.rearm_done = !(k_r < n_r) || (k_r + 1'b1 == n_r);
  assign sts.emit_last = (n_r == '0) || (k_r + 1'b1 == n_r);
  assign sts.cmd = cmd_r;

  always_ff @(posedge clk) begin
    if (cmd.emit_load || cmd.emit_adv) begin
      out_any_armed <= best_ok_r;
      out_next_deadline <= best_ok_r ? 48'(best_r) : 48'd0;
    end
  end

  always_comb begin
    out_fired_id = '0;
    out_earliest_changed = 1'b0;
    out_last = 1'b1;
    case (cmd_r)
      CMD_ADD: begin
        out_kind = KIND_ADD;
        out_earliest_changed = chg_r;
      end
      CMD_CANCEL: out_kind = KIND_CANCEL;
      default: begin
        if (n_r == '0) begin
          out_kind = KIND_IDLE;
        end else begin
          out_kind = KIND_FIRED;
          out_fired_id = 4'(list_r[LW'(k_r)]);
          out_last = (k_r + 1'b1 == n_r);
        end
      end
    endcase
  end
endmodule
`default_nettype wire

// File: design/deadline_timer_table.sv
// deadline timer table: up to SLOTS timers with deadline and repeat interval
// input beats on in_*: add, cancel or tick with the current time
// each add or cancel gives one result beat; a tick gives one beat per
// expired slot in deadline order (out_tlast on the final one), or one
// "none expired" beat
// each scan walks the slot table one entry a cycle through a single read port
// and waits for the read of an armed last slot to drain before it ends
// one command is worked at a time; in_tready is low until its last result
// beat is taken
// when the receiver stalls, the current result holds on out_* and the
// block waits
// reset clears all armed flags; deadlines and periods are written on add
`default_nettype none
module deadline_timer_table #(
  parameter int SLOTS = dtt_pkg::SLOTS_DEF,
  parameter int TIME_BITS = dtt_pkg::TIME_BITS_DEF
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_tvalid,
  output logic         in_tready,
  input  wire  [103:0] in_tdata,  // slot_id, time_us, repeat_us
  input  wire  [1:0]   in_tuser,  // cmd
  output logic         out_tvalid,
  input  wire          out_tready,
  output logic [55:0]  out_tdata, // fired_id, earliest_changed, any_armed, next_deadline
  output logic [1:0]   out_tuser, // kind
  output logic         out_tlast
);
  import dtt_pkg::*;

  dtt_cmd_t cmd;
  dtt_sts_t sts;
  logic busy;
  logic [3:0] fired_id;
  logic chg, any;
  logic [47:0] nd;

  assign in_tready = !busy;

  dtt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .busy(busy),
    .out_valid(out_tvalid), .out_ready(out_tready), .cmd(cmd), .sts(sts)
  );

  dtt_dpath #(.SLOTS(SLOTS), .TIME_BITS(TIME_BITS)) u_dpath (
    .clk(clk), .rst_n(rst_n), .in_cmd(in_tuser), .in_slot_id(in_tdata[3:0]),
    .in_time_us(in_tdata[51:4]), .in_repeat_us(in_tdata[99:52]),
    .cmd(cmd), .sts(sts), .out_kind(out_tuser), .out_fired_id(fired_id),
    .out_earliest_changed(chg), .out_any_armed(any),
    .out_next_deadline(nd), .out_last(out_tlast)
  );

  assign out_tdata = {2'b00, nd, any, chg, fired_id};
endmodule
`default_nettype wire

// File: design/dtt_checker.sv
`default_nettype none
module dtt_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tvalid,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [55:0] out_tdata,
  input wire [1:0]  out_tuser,
  input wire        out_tlast
);
  import dtt_pkg::*;

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input taken while result pending");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != KIND_FIRED |-> out_tlast)
    else $error("single result without last");
  a_any_deadline: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[5] |-> out_tdata[53:6] == 48'd0)
    else $error("deadline without armed slot");
endmodule

bind deadline_timer_table dtt_checker u_dtt_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);
`default_nettype wire
